/* hdl/pfa_pkg.sv */
`default_nettype none

package pfa_pkg;

    // Table geometry and field widths.
    localparam int LEN_W     = 20;
    localparam int MAX_PARTS = 64;
    localparam int AW        = $clog2(MAX_PARTS);
    localparam int CNT_W     = $clog2(MAX_PARTS + 1);
    localparam int SUM_W     = LEN_W + CNT_W;
    localparam int TAG_W     = 7;
    localparam int CMP_W     = LEN_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] PARTS_FULL = CNT_W'(MAX_PARTS);

    // Item kinds.
    localparam logic [1:0] KIND_BUILD = 2'd0;
    localparam logic [1:0] KIND_ADD   = 2'd1;
    localparam logic [1:0] KIND_ALLOC = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_OVER  = 2'd3;

    // Fit policies.
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;
    localparam logic [1:0] FIT_NEXT  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LEN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_SIZE  = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [LEN_W-1:0] part_length;
        logic [LEN_W-1:0] request_size;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [TAG_W-1:0] part_tag;
        logic [LEN_W-1:0] part_size;
        logic [LEN_W-1:0] used_size;
    } out_item_t;

endpackage

`default_nettype wire

/* hdl/partition_fit_allocator.sv */
`default_nettype none

// Partition fit allocator. Items arrive on in_valid/in_stall and each of kind
// build, add or allocate yields one result on out_valid/out_stall; kind three
// is dropped without a result. The block takes one item at a time. An add, a
// build in list layout, a fixed build with zero partition size and an allocate
// on an empty table go straight to the result. A fixed-layout build first runs
// the 20-step shift-subtract divider and then fills the length table, unless
// the layout would need too many partitions. An allocate scans the table,
// reading one table entry per cycle through the single read port of the length
// memory and comparing it against the request and the best candidate so far.
// First and next fit stop at the first fitting entry. The result register lets
// the next item be taken while a result still waits for the receiver; a second
// result holds the block until it can move.
module partition_fit_allocator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire pfa_pkg::in_item_t             in_item,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output pfa_pkg::out_item_t                 out_item,
    input  wire logic                          cfg_we,
    input  wire logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pfa_pkg::LEN_W-1:0]     cfg_data
);
    import pfa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_FILL = 5'b00100,
        S_SCAN = 5'b01000,
        S_RESP = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [1:0]       fit_mode_reg;
    logic             layout_reg;
    logic [LEN_W-1:0] total_reg;
    logic [LEN_W-1:0] fsize_reg;

    // Table bookkeeping.
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [SUM_W-1:0]     listed_reg, listed_next;
    logic [AW-1:0]        last_reg, last_next;
    logic [MAX_PARTS-1:0] taken_reg, taken_next;

    // Item and result holding.
    logic [LEN_W-1:0] req_reg, req_next;
    out_item_t        res_reg, res_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_item_reg;
    logic             out_load;

    // Scan state.
    logic [CNT_W-1:0] iss_cnt_reg, iss_cnt_next;
    logic [AW-1:0]    iss_pos_reg, iss_pos_next;
    logic             ev_valid_reg, ev_valid_next;
    logic [AW-1:0]    ev_idx_reg, ev_idx_next;
    logic             found_reg, found_next;
    logic [AW-1:0]    pick_reg, pick_next;
    logic [LEN_W-1:0] pick_len_reg, pick_len_next;

    // Fixed layout fill state.
    logic [CNT_W-1:0] fill_cnt_reg, fill_cnt_next;
    logic [CNT_W-1:0] fill_n_reg, fill_n_next;

    // Memory and divider connections.
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [LEN_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [LEN_W-1:0] mem_rdata;
    logic             div_start;
    logic             div_done;
    logic [LEN_W-1:0] div_quot;
    logic [LEN_W-1:0] div_rem;

    // Helper terms.
    logic             accept;
    logic             early_mode;
    logic             scan_done;
    logic             issue;
    logic             cand;
    logic             take;
    logic [CMP_W-1:0] fill_total;
    logic [LEN_W-1:0] list_rest;
    logic [CNT_W-1:0] last_inc;

    pfa_len_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pfa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (total_reg),
        .divisor  (fsize_reg),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_load = (state_reg == S_RESP) && (!out_valid_reg || !out_stall);

    assign early_mode = (fit_mode_reg == FIT_FIRST) || (fit_mode_reg == FIT_NEXT);
    assign scan_done  = (early_mode && found_reg) || ((iss_cnt_reg == count_reg) && !ev_valid_reg);
    assign issue      = !scan_done && (iss_cnt_reg != count_reg);

    // Shared compare unit: the entry under evaluation against request and best.
    assign cand = ev_valid_reg && !taken_reg[ev_idx_reg] && (mem_rdata >= req_reg);
    assign take = cand && (!found_reg
                  || ((fit_mode_reg == FIT_BEST) && (mem_rdata < pick_len_reg))
                  || ((fit_mode_reg == FIT_WORST) && (mem_rdata > pick_len_reg)));

    assign fill_total = CMP_W'(div_quot) + CMP_W'(div_rem != '0);
    assign list_rest  = total_reg - listed_reg[LEN_W-1:0];
    assign last_inc   = CNT_W'(last_reg) + CNT_W'(1);

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        listed_next   = listed_reg;
        last_next     = last_reg;
        taken_next    = taken_reg;
        req_next      = req_reg;
        res_next      = res_reg;
        iss_cnt_next  = iss_cnt_reg;
        iss_pos_next  = iss_pos_reg;
        ev_valid_next = 1'b0;
        ev_idx_next   = ev_idx_reg;
        found_next    = found_reg;
        pick_next     = pick_reg;
        pick_len_next = pick_len_reg;
        fill_cnt_next = fill_cnt_reg;
        fill_n_next   = fill_n_reg;
        mem_we        = 1'b0;
        mem_waddr     = count_reg[AW-1:0];
        mem_wdata     = in_item.part_length;
        mem_raddr     = iss_pos_reg;
        div_start     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next = in_item.request_size;
                    res_next = '{status: ST_OK, part_tag: '0, part_size: '0, used_size: '0};
                    unique case (in_item.kind)
                        KIND_BUILD:
                        begin
                            state_next = S_RESP;
                            if (!layout_reg)
                            begin
                                // Fixed layout starts from an empty table.
                                count_next  = '0;
                                listed_next = '0;
                                last_next   = '0;
                                taken_next  = '0;
                                if (fsize_reg == '0)
                                begin
                                    res_next.status = ST_BAD;
                                end
                                else
                                begin
                                    div_start  = 1'b1;
                                    state_next = S_DIV;
                                end
                            end
                            else if (listed_reg > SUM_W'(total_reg))
                            begin
                                res_next.status = ST_OVER;
                            end
                            else if (list_rest == '0)
                            begin
                                listed_next       = SUM_W'(total_reg);
                                res_next.part_tag = TAG_W'(count_reg);
                            end
                            else if (count_reg == PARTS_FULL)
                            begin
                                res_next.status = ST_BAD;
                            end
                            else
                            begin
                                // Append what is left of the total.
                                mem_we                        = 1'b1;
                                mem_wdata                     = list_rest;
                                taken_next[count_reg[AW-1:0]] = 1'b0;
                                count_next                    = count_reg + CNT_W'(1);
                                listed_next                   = SUM_W'(total_reg);
                                res_next.part_tag = TAG_W'(count_reg) + TAG_W'(1);
                            end
                        end
                        KIND_ADD:
                        begin
                            state_next = S_RESP;
                            if ((in_item.part_length == '0) || (count_reg == PARTS_FULL))
                            begin
                                res_next.status = ST_BAD;
                            end
                            else
                            begin
                                mem_we                        = 1'b1;
                                taken_next[count_reg[AW-1:0]] = 1'b0;
                                count_next  = count_reg + CNT_W'(1);
                                listed_next = listed_reg + SUM_W'(in_item.part_length);
                                res_next.part_tag  = TAG_W'(count_reg) + TAG_W'(1);
                                res_next.part_size = in_item.part_length;
                            end
                        end
                        KIND_ALLOC:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = ST_NOFIT;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                iss_cnt_next = '0;
                                found_next   = 1'b0;
                                if ((fit_mode_reg == FIT_NEXT) && (last_inc != count_reg))
                                begin
                                    iss_pos_next = last_inc[AW-1:0];
                                end
                                else
                                begin
                                    iss_pos_next = '0;
                                end
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    if (fill_total > CMP_W'(MAX_PARTS))
                    begin
                        res_next.status = ST_BAD;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        fill_n_next   = CNT_W'(fill_total);
                        fill_cnt_next = '0;
                        state_next    = S_FILL;
                    end
                end
            end

            S_FILL:
            begin
                // One partition written per cycle, remainder last.
                if (fill_cnt_reg == fill_n_reg)
                begin
                    count_next        = fill_n_reg;
                    res_next.part_tag = TAG_W'(fill_n_reg);
                    state_next        = S_RESP;
                end
                else
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = fill_cnt_reg[AW-1:0];
                    mem_wdata     = (CMP_W'(fill_cnt_reg) < CMP_W'(div_quot)) ? fsize_reg : div_rem;
                    fill_cnt_next = fill_cnt_reg + CNT_W'(1);
                end
            end

            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_RESP;
                    if (found_reg)
                    begin
                        taken_next[pick_reg] = 1'b1;
                        if (fit_mode_reg == FIT_NEXT)
                        begin
                            last_next = pick_reg;
                        end
                        res_next.part_tag  = TAG_W'({1'b0, pick_reg}) + TAG_W'(1);
                        res_next.part_size = pick_len_reg;
                        res_next.used_size = req_reg;
                    end
                    else
                    begin
                        res_next.status = ST_NOFIT;
                    end
                end
                else
                begin
                    // Issue the next read, wrapping at the table end.
                    if (issue)
                    begin
                        ev_valid_next = 1'b1;
                        ev_idx_next   = iss_pos_reg;
                        iss_cnt_next  = iss_cnt_reg + CNT_W'(1);
                        if (CNT_W'(iss_pos_reg) == (count_reg - CNT_W'(1)))
                        begin
                            iss_pos_next = '0;
                        end
                        else
                        begin
                            iss_pos_next = iss_pos_reg + AW'(1);
                        end
                    end
                    // Keep the candidate that wins under the fit policy.
                    if (take)
                    begin
                        found_next    = 1'b1;
                        pick_next     = ev_idx_reg;
                        pick_len_next = mem_rdata;
                    end
                end
            end

            S_RESP:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fit_mode_reg  <= FIT_FIRST;
            layout_reg    <= 1'b0;
            total_reg     <= '0;
            fsize_reg     <= LEN_W'(1);
            count_reg     <= '0;
            listed_reg    <= '0;
            last_reg      <= '0;
            taken_reg     <= '0;
            out_valid_reg <= 1'b0;
            ev_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            iss_cnt_reg   <= '0;
            fill_cnt_reg  <= '0;
            fill_n_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            listed_reg    <= listed_next;
            last_reg      <= last_next;
            taken_reg     <= taken_next;
            out_valid_reg <= out_valid_next;
            ev_valid_reg  <= ev_valid_next;
            found_reg     <= found_next;
            iss_cnt_reg   <= iss_cnt_next;
            fill_cnt_reg  <= fill_cnt_next;
            fill_n_reg    <= fill_n_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FIT_MODE:    fit_mode_reg <= cfg_data[1:0];
                    CFG_LAYOUT_MODE: layout_reg   <= cfg_data[0];
                    CFG_TOTAL_LEN:   total_reg    <= cfg_data;
                    CFG_FIXED_SIZE:  fsize_reg    <= cfg_data;
                    default:         fit_mode_reg <= fit_mode_reg;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        res_reg      <= res_next;
        iss_pos_reg  <= iss_pos_next;
        ev_idx_reg   <= ev_idx_next;
        pick_reg     <= pick_next;
        pick_len_reg <= pick_len_next;
        if (out_load)
        begin
            out_item_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

/* hdl/pfa_div.sv */
`default_nettype none

module pfa_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [pfa_pkg::LEN_W-1:0] dividend,
    input  wire logic [pfa_pkg::LEN_W-1:0] divisor,
    output logic                           done,
    output logic [pfa_pkg::LEN_W-1:0]      quot,
    output logic [pfa_pkg::LEN_W-1:0]      rem
);
    import pfa_pkg::*;

    localparam int STEP_W = $clog2(LEN_W + 1);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;
    logic [LEN_W:0]    a_reg, a_next;
    logic [LEN_W-1:0]  q_reg, q_next;
    logic [LEN_W-1:0]  d_reg, d_next;
    logic [LEN_W:0]    a_shift;
    logic              ge;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign a_shift = {a_reg[LEN_W-1:0], q_reg[LEN_W-1]};
    assign ge      = a_shift >= {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            a_next    = '0;
            q_next    = dividend;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            a_next    = ge ? (a_shift - {1'b0, d_reg}) : a_shift;
            q_next    = {q_reg[LEN_W-2:0], ge};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(LEN_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        q_reg <= q_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = a_reg[LEN_W-1:0];

endmodule

`default_nettype wire

/* hdl/pfa_len_mem.sv */
`default_nettype none

module pfa_len_mem (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [pfa_pkg::AW-1:0]    waddr,
    input  wire logic [pfa_pkg::LEN_W-1:0] wdata,
    input  wire logic [pfa_pkg::AW-1:0]    raddr,
    output logic [pfa_pkg::LEN_W-1:0]      rdata
);
    import pfa_pkg::*;

    logic [LEN_W-1:0] mem [MAX_PARTS];
    logic [LEN_W-1:0] rdata_reg;

    // Partition lengths: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/pfa_checker.sv */
`default_nettype none

module pfa_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire pfa_pkg::in_item_t             in_item,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire pfa_pkg::out_item_t            out_item
);
    import pfa_pkg::*;

    // A result held back by the receiver stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed or vanished");

    // Any item that makes a result keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_item.kind != KIND_RSVD) |=> in_stall)
        else $error("block took a second item while working");

    // An item of the reserved kind is dropped and the block stays open.
    a_rsvd_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_item.kind == KIND_RSVD) |=> !in_stall)
        else $error("reserved item was not dropped");

    // A failed item reports no partition.
    a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.status != ST_OK) |->
            (out_item.part_tag == '0) && (out_item.part_size == '0)
            && (out_item.used_size == '0))
        else $error("failed result carries partition data");

endmodule

bind partition_fit_allocator pfa_checker u_pfa_checker (.*);

`default_nettype wire
